// ===== rtl/core/c_subset_lexer_core_assert.svh =====
// Assertion macros for the C subset lexer core.
// Used by c_subset_lexer_core; expects clk and arst_n in scope.
`ifndef C_SUBSET_LEXER_CORE_ASSERT_SVH
`define C_SUBSET_LEXER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSLX_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) expr) \
		else $error("c_subset_lexer_core: assertion failed");
`define CSLX_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("c_subset_lexer_core: forbidden condition seen");
`else
`define CSLX_ASSERT(label, expr)
`define CSLX_NEVER(label, cond)
`endif
`endif

// ===== rtl/core/cslx_pkg.sv =====
// Shared constants, keyword tables and character classes of the C subset lexer.
// No dependencies.
package cslx_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 30;
	localparam int KW_COUNT = 8;
	localparam int KW_SLOTS = 8;

	typedef enum logic [2:0] {
		KIND_KEYWORD = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_CONST   = 3'd2,
		KIND_OPER    = 3'd3,
		KIND_SYMBOL  = 3'd4
	} token_kind_t;

	localparam logic [7:0] KW_CHARS [KW_COUNT][KW_SLOTS] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] KW_LENS [KW_COUNT] = '{
		3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "%") || (c == "=") ||
			(c == ">") || (c == "<") || (c == "!") || (c == "&") || (c == "|") ||
			(c == "^");
	endfunction

	// byte that yields a symbol token when seen in idle mode
	function automatic logic is_symbol(input logic [7:0] c);
		return !is_space(c) && (c != "/") && !is_letter(c) && !is_digit(c) && !is_op(c);
	endfunction

endpackage

// ===== rtl/core/c_subset_lexer_core.sv =====
// Top level of the C subset lexer: byte requests in, token character requests out.
// Depends on cslx_pkg, cslx_ram and c_subset_lexer_core_assert.svh.
//
//   channel  handshake            payload
//   input    in_valid / in_stall   text_byte, end_of_text
//   output   out_valid / out_stall token_kind, token_char, token_end, run_end
//
// Each byte is accepted in C_IDLE and evaluated in C_EXEC; an operator pair adds
// C_PAIR, and a byte ending a lone slash or single operator is evaluated again.
// A finished identifier or constant drains from the token RAM at one character per
// cycle unless out_stall holds it, then the ending byte is examined again.
// Reset clears control state only; token RAM contents are undefined until written.
// out_stall holds the output register and the sequencer waits on it.
`include "c_subset_lexer_core_assert.svh"
module c_subset_lexer_core #(
	parameter int MAX_TOKEN_LEN = cslx_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] token_kind,
	output logic [7:0] token_char,
	output logic       token_end,
	output logic       run_end
);
	import cslx_pkg::*;

	localparam int IDX_W = $clog2(MAX_TOKEN_LEN);
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

	typedef enum logic [7:0] {
		LM_IDLE  = 8'b0000_0001,
		LM_SLASH = 8'b0000_0010,
		LM_LINE  = 8'b0000_0100,
		LM_BLOCK = 8'b0000_1000,
		LM_STAR  = 8'b0001_0000,
		LM_IDENT = 8'b0010_0000,
		LM_CONST = 8'b0100_0000,
		LM_OPER  = 8'b1000_0000
	} lex_mode_t;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_EXEC = 4'b0010,
		C_PAIR = 4'b0100,
		C_FOUT = 4'b1000
	} ctl_t;

	ctl_t                ctl_q, ctl_d;
	lex_mode_t           lm_q, lm_d;
	logic [7:0]          byte_q;
	logic                eot_q;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [7:0]          pend_q, pend_d;
	logic [KW_COUNT-1:0] kw_m_q, kw_m_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	token_kind_t         kind_q, kind_d;
	logic                again_q, again_d;
	logic                sym_after_q, sym_after_d;

	logic                out_valid_q;
	token_kind_t         out_kind_q;
	logic [7:0]          out_char_q;
	logic                out_end_q;
	logic                out_run_q;

	logic                ld;
	token_kind_t         ld_kind;
	logic [7:0]          ld_char;
	logic                ld_end;
	logic                ld_run;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [7:0]          rd_data;

	logic                accept;
	logic                out_free;
	logic                kw_hit;
	logic                sym_c;
	logic                fout_last;
	logic [IDX_W-1:0]    idx_nx;

	cslx_ram #(
		.WIDTH(8),
		.DEPTH(MAX_TOKEN_LEN)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (byte_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (ctl_q != C_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign sym_c     = is_symbol(byte_q);
	assign idx_nx    = idx_q + IDX_W'(1);
	assign fout_last = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;

	always_comb begin
		kw_hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (kw_m_q[k] && len_q == LEN_W'(KW_LENS[k])) begin
				kw_hit = 1'b1;
			end
		end
	end

	always_comb begin
		ctl_d       = ctl_q;
		lm_d        = lm_q;
		len_d       = len_q;
		pend_d      = pend_q;
		kw_m_d      = kw_m_q;
		idx_d       = idx_q;
		kind_d      = kind_q;
		again_d     = again_q;
		sym_after_d = sym_after_q;
		ld          = 1'b0;
		ld_kind     = KIND_OPER;
		ld_char     = byte_q;
		ld_end      = 1'b1;
		ld_run      = 1'b1;
		wr_en       = 1'b0;
		wr_addr     = '0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		case (ctl_q)
			C_IDLE: begin
				if (in_valid) begin
					ctl_d = C_EXEC;
				end
			end
			C_EXEC: begin
				if (eot_q) begin
					case (lm_q)
						LM_SLASH, LM_OPER: begin
							if (out_free) begin
								ld      = 1'b1;
								ld_char = (lm_q == LM_SLASH) ? 8'("/") : pend_q;
								lm_d    = LM_IDLE;
								len_d   = '0;
								pend_d  = '0;
								ctl_d   = C_IDLE;
							end
						end
						LM_IDENT, LM_CONST: begin
							rd_en       = 1'b1;
							idx_d       = '0;
							kind_d      = (lm_q == LM_CONST) ? KIND_CONST :
								(kw_hit ? KIND_KEYWORD : KIND_IDENT);
							again_d     = 1'b0;
							sym_after_d = 1'b0;
							ctl_d       = C_FOUT;
						end
						default: begin
							lm_d   = LM_IDLE;
							len_d  = '0;
							pend_d = '0;
							ctl_d  = C_IDLE;
						end
					endcase
				end else begin
					case (lm_q)
						LM_IDLE: begin
							ctl_d = C_IDLE;
							if (is_space(byte_q)) begin
								lm_d = LM_IDLE;
							end else if (byte_q == "/") begin
								lm_d = LM_SLASH;
							end else if (is_letter(byte_q) || is_digit(byte_q)) begin
								wr_en = 1'b1;
								len_d = LEN_W'(1);
								lm_d  = is_digit(byte_q) ? LM_CONST : LM_IDENT;
								for (int k = 0; k < KW_COUNT; k++) begin
									kw_m_d[k] = (byte_q == KW_CHARS[k][0]);
								end
							end else if (is_op(byte_q)) begin
								pend_d = byte_q;
								lm_d   = LM_OPER;
							end else if (out_free) begin
								ld      = 1'b1;
								ld_kind = KIND_SYMBOL;
							end else begin
								ctl_d = C_EXEC;
							end
						end
						LM_SLASH: begin
							if (byte_q == "/") begin
								lm_d  = LM_LINE;
								ctl_d = C_IDLE;
							end else if (byte_q == "*") begin
								lm_d  = LM_BLOCK;
								ctl_d = C_IDLE;
							end else if (out_free) begin
								ld      = 1'b1;
								ld_char = 8'("/");
								ld_run  = !sym_c;
								lm_d    = LM_IDLE;
							end
						end
						LM_LINE: begin
							if (byte_q == 8'h0a) begin
								lm_d = LM_IDLE;
							end
							ctl_d = C_IDLE;
						end
						LM_BLOCK: begin
							if (byte_q == "*") begin
								lm_d = LM_STAR;
							end
							ctl_d = C_IDLE;
						end
						LM_STAR: begin
							if (byte_q == "/") begin
								lm_d = LM_IDLE;
							end else if (byte_q != "*") begin
								lm_d = LM_BLOCK;
							end
							ctl_d = C_IDLE;
						end
						LM_IDENT, LM_CONST: begin
							if ((lm_q == LM_IDENT && (is_letter(byte_q) || is_digit(byte_q))) ||
								(lm_q == LM_CONST && (is_digit(byte_q) || byte_q == "."))) begin
								ctl_d = C_IDLE;
								if (len_q < LEN_W'(MAX_TOKEN_LEN)) begin
									wr_en   = 1'b1;
									wr_addr = len_q[IDX_W-1:0];
									len_d   = len_q + LEN_W'(1);
									for (int k = 0; k < KW_COUNT; k++) begin
										kw_m_d[k] = kw_m_q[k] && (len_q < LEN_W'(KW_LENS[k])) &&
											(byte_q == KW_CHARS[k][len_q[2:0]]);
									end
								end
							end else begin
								rd_en       = 1'b1;
								idx_d       = '0;
								kind_d      = (lm_q == LM_CONST) ? KIND_CONST :
									(kw_hit ? KIND_KEYWORD : KIND_IDENT);
								again_d     = 1'b1;
								sym_after_d = sym_c;
								ctl_d       = C_FOUT;
							end
						end
						LM_OPER: begin
							if (out_free) begin
								ld      = 1'b1;
								ld_char = pend_q;
								if (is_op(byte_q)) begin
									ld_end = 1'b0;
									ld_run = 1'b0;
									ctl_d  = C_PAIR;
								end else begin
									ld_run = !sym_c;
									lm_d   = LM_IDLE;
									pend_d = '0;
								end
							end
						end
						default: begin
							lm_d  = LM_IDLE;
							ctl_d = C_IDLE;
						end
					endcase
				end
			end
			C_PAIR: begin
				if (out_free) begin
					ld     = 1'b1;
					lm_d   = LM_IDLE;
					pend_d = '0;
					ctl_d  = C_IDLE;
				end
			end
			C_FOUT: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = kind_q;
					ld_char = rd_data;
					ld_end  = fout_last;
					ld_run  = fout_last && !sym_after_q;
					if (fout_last) begin
						len_d  = '0;
						pend_d = '0;
						lm_d   = LM_IDLE;
						ctl_d  = again_q ? C_EXEC : C_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_nx;
						idx_d   = idx_nx;
					end
				end
			end
			default: begin
				ctl_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= C_IDLE;
			lm_q        <= LM_IDLE;
			len_q       <= '0;
			pend_q      <= '0;
			kw_m_q      <= '0;
			idx_q       <= '0;
			kind_q      <= KIND_IDENT;
			again_q     <= 1'b0;
			sym_after_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ctl_q       <= ctl_d;
			lm_q        <= lm_d;
			len_q       <= len_d;
			pend_q      <= pend_d;
			kw_m_q      <= kw_m_d;
			idx_q       <= idx_d;
			kind_q      <= kind_d;
			again_q     <= again_d;
			sym_after_q <= sym_after_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= text_byte;
			eot_q  <= end_of_text;
		end
		if (ld) begin
			out_kind_q <= ld_kind;
			out_char_q <= ld_char;
			out_end_q  <= ld_end;
			out_run_q  <= ld_run;
		end
	end

	assign out_valid  = out_valid_q;
	assign token_kind = out_kind_q;
	assign token_char = out_char_q;
	assign token_end  = out_end_q;
	assign run_end    = out_run_q;

	`CSLX_ASSERT(a_accept_exec, (in_valid && !in_stall) |=> (ctl_q == C_EXEC))
	`CSLX_ASSERT(a_fout_idx, (ctl_q == C_FOUT) |-> (LEN_W'(idx_q) < len_q))
	`CSLX_NEVER(a_len_range, len_q > LEN_W'(MAX_TOKEN_LEN))
	`CSLX_ASSERT(a_buf_len, (lm_q == LM_IDENT || lm_q == LM_CONST) |-> (len_q != '0))

endmodule

// ===== rtl/core/cslx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cslx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== verif/c_subset_lexer_core_tb.sv =====
// Self-checking testbench for c_subset_lexer_core: byte requests in, token character
// requests out, both with random valid/stall gaps, checked against an in-bench lexer.
// Depends on cslx_pkg and the c_subset_lexer_core RTL.
`timescale 1ns / 1ps
module c_subset_lexer_core_tb;

	import cslx_pkg::token_kind_t;
	import cslx_pkg::KIND_KEYWORD;
	import cslx_pkg::KIND_IDENT;
	import cslx_pkg::KIND_CONST;
	import cslx_pkg::KIND_OPER;
	import cslx_pkg::KIND_SYMBOL;

	localparam int TOKEN_MAX   = 30;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 300;
	localparam int DRAIN_CYCLES = 200;

	typedef enum logic [2:0] {
		LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_STAR, LX_WORD, LX_NUM, LX_OPER
	} lex_state_t;

	typedef struct {
		byte unsigned ch;
		bit           eot;
	} text_req_t;

	typedef struct {
		token_kind_t  kind;
		byte unsigned ch;
		bit           tok_last;
		bit           run_last;
	} token_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] token_kind;
	logic [7:0] token_char;
	logic       token_end;
	logic       run_end;

	text_req_t  text_q[$];
	token_req_t token_exp_q[$];
	token_req_t step_q[$];

	string kw_words[8] = '{"int", "float", "if", "else", "while", "for", "return", "void"};
	string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string word_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string num_body  = "0123456789.";
	string op_chars  = "+-*%=><!&|^";

	// lexer state of the predictor
	lex_state_t   lx_mode = LX_IDLE;
	byte unsigned tok_buf [TOKEN_MAX];
	int           tok_len = 0;
	byte unsigned pend_op = 8'h00;

	int total_items = 0;
	int accepted = 0;
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit drv_calm = 1'b0;
	bit mon_calm = 1'b0;

	c_subset_lexer_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_char  (token_char),
		.token_end   (token_end),
		.run_end     (run_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit blank_char(byte unsigned c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic bit head_char(byte unsigned c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit num_char(byte unsigned c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit oper_char(byte unsigned c);
		for (int i = 0; i < op_chars.len(); i++)
			if (c == op_chars[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void emit(token_kind_t k, byte unsigned c, bit last);
		token_req_t r;
		r.kind = k;
		r.ch = c;
		r.tok_last = last;
		r.run_last = 1'b0;
		step_q.push_back(r);
	endfunction

	function automatic bit word_is_keyword();
		bit same;
		for (int k = 0; k < 8; k++) begin
			if (tok_len == kw_words[k].len()) begin
				same = 1'b1;
				for (int i = 0; i < tok_len; i++)
					if (tok_buf[i] != kw_words[k][i])
						same = 1'b0;
				if (same)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void emit_buffer(token_kind_t k);
		for (int i = 0; i < tok_len; i++)
			emit(k, tok_buf[i], i + 1 == tok_len);
		tok_len = 0;
	endfunction

	function automatic void append_char(byte unsigned c);
		if (tok_len < TOKEN_MAX) begin
			tok_buf[tok_len] = c;
			tok_len++;
		end
	endfunction

	function automatic void close_pending();
		case (lx_mode)
			LX_SLASH: emit(KIND_OPER, "/", 1'b1);
			LX_WORD:  emit_buffer(word_is_keyword() ? KIND_KEYWORD : KIND_IDENT);
			LX_NUM:   emit_buffer(KIND_CONST);
			LX_OPER:  emit(KIND_OPER, pend_op, 1'b1);
			default: ;
		endcase
		lx_mode = LX_IDLE;
		tok_len = 0;
		pend_op = 8'h00;
	endfunction

	// returns 1 when the byte ends a token and must be looked at again
	function automatic bit lex_consume(byte unsigned c);
		case (lx_mode)
			LX_SLASH: begin
				if (c == "/") begin
					lx_mode = LX_LINE;
					return 1'b0;
				end
				if (c == "*") begin
					lx_mode = LX_BLOCK;
					return 1'b0;
				end
				close_pending();
				return 1'b1;
			end
			LX_LINE: begin
				if (c == 8'h0a)
					lx_mode = LX_IDLE;
				return 1'b0;
			end
			LX_BLOCK: begin
				if (c == "*")
					lx_mode = LX_STAR;
				return 1'b0;
			end
			LX_STAR: begin
				if (c == "/")
					lx_mode = LX_IDLE;
				else if (c != "*")
					lx_mode = LX_BLOCK;
				return 1'b0;
			end
			LX_WORD: begin
				if (head_char(c) || num_char(c)) begin
					append_char(c);
					return 1'b0;
				end
				close_pending();
				return 1'b1;
			end
			LX_NUM: begin
				if (num_char(c) || c == ".") begin
					append_char(c);
					return 1'b0;
				end
				close_pending();
				return 1'b1;
			end
			LX_OPER: begin
				if (oper_char(c)) begin
					emit(KIND_OPER, pend_op, 1'b0);
					emit(KIND_OPER, c, 1'b1);
					lx_mode = LX_IDLE;
					pend_op = 8'h00;
					return 1'b0;
				end
				close_pending();
				return 1'b1;
			end
			default: begin
				lx_mode = LX_IDLE;
				if (blank_char(c))
					return 1'b0;
				if (c == "/")
					lx_mode = LX_SLASH;
				else if (head_char(c)) begin
					tok_buf[0] = c;
					tok_len = 1;
					lx_mode = LX_WORD;
				end else if (num_char(c)) begin
					tok_buf[0] = c;
					tok_len = 1;
					lx_mode = LX_NUM;
				end else if (oper_char(c)) begin
					pend_op = c;
					lx_mode = LX_OPER;
				end else
					emit(KIND_SYMBOL, c, 1'b1);
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void predict_tokens(byte unsigned c, bit eot);
		step_q.delete();
		if (eot)
			close_pending();
		else if (lex_consume(c))
			void'(lex_consume(c));
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].run_last = 1'b1;
		foreach (step_q[i])
			token_exp_q.push_back(step_q[i]);
	endfunction

	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		text_req_t nxt;
		int g;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if ($urandom_range(0, 39) == 0)
				drv_calm = !drv_calm;
			if (in_valid && !in_stall) begin
				predict_tokens(text_byte, end_of_text);
				accepted++;
				g = draw_wait(drv_calm);
				if (text_q.size() != 0 && g == 0) begin
					nxt = text_q.pop_front();
					text_byte <= nxt.ch;
					end_of_text <= nxt.eot;
				end else begin
					in_valid <= 1'b0;
					gap_left <= g;
				end
			end else if (!in_valid) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else if (text_q.size() != 0) begin
					nxt = text_q.pop_front();
					text_byte <= nxt.ch;
					end_of_text <= nxt.eot;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		token_req_t e;
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if ($urandom_range(0, 39) == 0)
				mon_calm = !mon_calm;
			if (out_valid && !out_stall) begin
				if (token_exp_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected token request: kind %0d char %02h end %0b run %0b",
							token_kind, token_char, token_end, run_end);
				end else begin
					e = token_exp_q.pop_front();
					if (token_kind != e.kind || token_char != e.ch ||
						token_end != e.tok_last || run_end != e.run_last) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: kind exp %0d got %0d, char exp %02h got %02h,",
								" end exp %0b got %0b, run exp %0b got %0b"},
								e.kind, token_kind, e.ch, token_char, e.tok_last, token_end,
								e.run_last, run_end);
					end
				end
				n = draw_wait(mon_calm);
				if (n > 0) begin
					out_stall <= 1'b1;
					stall_left <= n;
				end
			end else if (out_stall) begin
				if (stall_left <= 1)
					out_stall <= 1'b0;
				stall_left <= stall_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** c_subset_lexer_core: FAILED **");
			$finish;
		end
	end

	task automatic add_byte(byte unsigned c);
		text_req_t r;
		r.ch = c;
		r.eot = 1'b0;
		text_q.push_back(r);
	endtask

	task automatic add_end();
		text_req_t r;
		r.ch = 8'($urandom_range(0, 255));
		r.eot = 1'b1;
		text_q.push_back(r);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic byte unsigned pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	initial begin
		int cat;
		int n;
		// directed: keyword cut by a high byte, constant flushed at end, operator pair,
		// single operator re-examined, line comment, block comment closed by stars,
		// slash before an operator, lone slash at end, control bytes
		add_text("if");
		add_byte(8'hff);
		add_text("9.");
		add_end();
		add_text("<=+a");
		add_end();
		add_text("//x");
		add_byte(8'h0a);
		add_text("/***//=/");
		add_end();
		add_byte(8'h00);
		add_byte(8'h7f);
		add_text("/*x");
		add_end();
		add_end();

		while (text_q.size() < RANDOM_ITEMS + 30) begin
			cat = $urandom_range(0, 99);
			if (cat < 15)
				add_text(kw_words[$urandom_range(0, 7)]);
			else if (cat < 30) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
				add_byte(pick(word_head));
				for (int i = 1; i < n; i++)
					add_byte(pick(word_body));
			end else if (cat < 40) begin
				n = ($urandom_range(0, 14) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
				add_byte(8'(8'h30 + $urandom_range(0, 9)));
				for (int i = 1; i < n; i++)
					add_byte(pick(num_body));
			end else if (cat < 50) begin
				add_byte(pick(op_chars));
				if ($urandom_range(0, 1))
					add_byte(pick(op_chars));
			end else if (cat < 58) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					add_byte(($urandom_range(0, 5) == 0) ? 8'h20 :
						8'(8'h09 + $urandom_range(0, 4)));
			end else if (cat < 63) begin
				add_text("//");
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					add_byte(8'($urandom_range(0, 255)));
				add_byte(8'h0a);
			end else if (cat < 70) begin
				add_text("/*");
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++)
					add_byte($urandom_range(0, 1) ? pick("ab */*\n") :
						8'($urandom_range(0, 255)));
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					add_byte("*");
				add_byte("/");
			end else if (cat < 76)
				add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) :
					pick("#;(){}[],.?:~@$"));
			else if (cat < 80) begin
				add_byte("/");
				add_byte(8'($urandom_range(0, 255)));
			end else if (cat < 85)
				add_end();
			else
				add_byte(8'($urandom_range(0, 255)));
		end
		add_end();
		total_items = text_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (accepted < total_items || token_exp_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && token_exp_q.size() == 0)
			$display("** c_subset_lexer_core: PASSED **");
		else
			$display("** c_subset_lexer_core: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cslx_pkg.sv
rtl/core/cslx_ram.sv
rtl/core/c_subset_lexer_core.sv
verif/c_subset_lexer_core_tb.sv
